/* hw/rtl/cpa_pkg.sv */
// Shared constants, result codes, scan result types and mask helpers of the page allocator.
package cpa_pkg;

    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 11;
    localparam int STAT_W     = 2;
    localparam int RUN_W      = CNT_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int WORD_BITS  = 16;
    localparam int OFF_W      = $clog2(WORD_BITS);

    localparam int NUM_PAGES_DEF  = 1024;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam logic [CNT_W-1:0] TOTAL_PAGES_RST = 11'd1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'd1;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADCOUNT = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic             hit;
        logic [OFF_W-1:0] pos;
        logic [RUN_W-1:0] carry;
    } t_search_res;

    typedef struct packed {
        logic                 found;
        logic [WORD_BITS-1:0] used_word;
        logic [WORD_BITS-1:0] end_word;
    } t_free_res;

    function automatic int word_addr_bits(input int num_pages);
        int nw;
        nw = (num_pages + WORD_BITS - 1) / WORD_BITS;
        return (nw > 1) ? $clog2(nw) : 1;
    endfunction

    // Bits lo to hi inclusive of one map word.
    function automatic logic [WORD_BITS-1:0] range_mask(input logic [OFF_W-1:0] lo,
                                                        input logic [OFF_W-1:0] hi);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++) begin
            m[i] = (OFF_W'(i) >= lo) && (OFF_W'(i) <= hi);
        end
        return m;
    endfunction

endpackage

/* hw/rtl/contiguous_page_allocator.sv */
// Top level of the first-fit contiguous page allocator: configuration registers and wiring.
//
//  Channel   Signals                                          Direction  Handshake
//  request   i_cmd, i_page_count, i_free_address              in         i_in_valid / o_in_ready
//  result    o_status, o_alloc_address                        out        o_out_valid / i_out_ready
//  config    i_cfg_index, i_cfg_data                          in         i_cfg_we, no wait
//
// One transaction is worked on at a time; the map is read as 16-page words through one
// memory read port. Allocate: a prep step, a search one word at a time up to the hit (at
// most ceil(pages in use / 16) words), a read of the run's first word, a write per word
// of the new run, then finish. Release: a prep step, a range check, a walk up to the run
// end, then finish. After reset a clearing pass writes zero to every map word; no request
// is taken during it. A held result stalls only the finish of the next one.
module contiguous_page_allocator import cpa_pkg::*; #(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [CNT_W-1:0]     i_page_count,
    input  logic [ADDR_W-1:0]    i_free_address,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [ADDR_W-1:0]    o_alloc_address,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    localparam int WA = word_addr_bits(NUM_PAGES);

    logic [ADDR_W-1:0]    r_base;
    logic [CNT_W-1:0]     r_total;
    logic [WA-1:0]        mem_raddr;
    logic                 mem_we;
    logic [WA-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wused;
    logic [WORD_BITS-1:0] mem_wend;
    logic [WORD_BITS-1:0] mem_rused;
    logic [WORD_BITS-1:0] mem_rend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_total <= TOTAL_PAGES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data;
                CFG_TOTAL: r_total <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cpa_map_mem #(
        .ADDR_BITS (WA)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wused (mem_wused),
        .i_wend  (mem_wend),
        .i_raddr (mem_raddr),
        .o_rused (mem_rused),
        .o_rend  (mem_rend)
    );

    cpa_ctrl #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_page_count    (i_page_count),
        .i_free_address  (i_free_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_alloc_address (o_alloc_address),
        .i_base          (r_base),
        .i_total         (r_total),
        .o_mem_raddr     (mem_raddr),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wused     (mem_wused),
        .o_mem_wend      (mem_wend),
        .i_mem_rused     (mem_rused),
        .i_mem_rend      (mem_rend)
    );

endmodule

/* hw/rtl/cpa_map_mem.sv */
// Word-wide page map: allocated marks and run-end marks, one write and one registered read port.
module cpa_map_mem import cpa_pkg::*; #(
    parameter int ADDR_BITS = word_addr_bits(NUM_PAGES_DEF)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WORD_BITS-1:0] i_wused,
    input  logic [WORD_BITS-1:0] i_wend,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WORD_BITS-1:0] o_rused,
    output logic [WORD_BITS-1:0] o_rend
);

    logic [WORD_BITS-1:0] r_used_mem [2**ADDR_BITS];
    logic [WORD_BITS-1:0] r_end_mem  [2**ADDR_BITS];
    logic [WORD_BITS-1:0] r_rused;
    logic [WORD_BITS-1:0] r_rend;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_used_mem[i_waddr] <= i_wused;
            r_end_mem[i_waddr]  <= i_wend;
        end
        r_rused <= r_used_mem[i_raddr];
        r_rend  <= r_end_mem[i_raddr];
    end

    assign o_rused = r_rused;
    assign o_rend  = r_rend;

endmodule

/* hw/rtl/cpa_word_scan.sv */
// Per-word logic: free-run search for allocation and run-end walk for release.
module cpa_word_scan import cpa_pkg::*; (
    input  logic [WORD_BITS-1:0] i_used,
    input  logic [WORD_BITS-1:0] i_end,
    input  logic [WORD_BITS-1:0] i_in_map,
    input  logic [RUN_W-1:0]     i_carry,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [OFF_W-1:0]     i_off,
    output t_search_res          o_search,
    output t_free_res            o_free
);

    logic [WORD_BITS-1:0] blocked;
    logic                 seen [WORD_BITS];
    logic [OFF_W-1:0]     last [WORD_BITS];
    logic [RUN_W-1:0]     run  [WORD_BITS];
    logic [WORD_BITS-1:0] hit;
    logic [WORD_BITS-1:0] ends;
    logic [OFF_W-1:0]     end_pos;
    logic [OFF_W-1:0]     clr_hi;

    // Pages outside the map in use count as taken, so no run crosses the limit.
    assign blocked = i_used | ~i_in_map;

    // The free run ending at each bit is either the distance to the nearest taken
    // bit below it, or the run carried in from earlier words plus the bits so far.
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            seen[j] = 1'b0;
            last[j] = '0;
            for (int i = 0; i <= j; i++) begin
                if (blocked[i]) begin
                    seen[j] = 1'b1;
                    last[j] = OFF_W'(i);
                end
            end
            run[j] = seen[j] ? RUN_W'(OFF_W'(j) - last[j])
                             : i_carry + RUN_W'(j) + RUN_W'(1);
            hit[j] = !blocked[j] && (run[j] >= RUN_W'(i_count));
        end
        o_search.hit   = |hit;
        o_search.pos   = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                o_search.pos = OFF_W'(j);
            end
        end
        o_search.carry = run[WORD_BITS-1];
    end

    assign ends = i_end & range_mask(i_off, OFF_W'(WORD_BITS - 1));

    always_comb begin
        end_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (ends[j]) begin
                end_pos = OFF_W'(j);
            end
        end
    end

    assign clr_hi           = (|ends) ? end_pos : OFF_W'(WORD_BITS - 1);
    assign o_free.found     = |ends;
    assign o_free.used_word = i_used & ~range_mask(i_off, clr_hi);
    assign o_free.end_word  = i_end & ~((|ends) ? (WORD_BITS'(1) << end_pos)
                                                : {WORD_BITS{1'b0}});

endmodule

/* hw/rtl/cpa_ctrl.sv */
// Sequencer: map clearing, first-fit search, run marking, release walk and result register.
module cpa_ctrl import cpa_pkg::*; #(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_cmd,
    input  logic [CNT_W-1:0]                      i_page_count,
    input  logic [ADDR_W-1:0]                     i_free_address,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [STAT_W-1:0]                     o_status,
    output logic [ADDR_W-1:0]                     o_alloc_address,
    input  logic [ADDR_W-1:0]                     i_base,
    input  logic [CNT_W-1:0]                      i_total,
    output logic [word_addr_bits(NUM_PAGES)-1:0]  o_mem_raddr,
    output logic                                  o_mem_we,
    output logic [word_addr_bits(NUM_PAGES)-1:0]  o_mem_waddr,
    output logic [WORD_BITS-1:0]                  o_mem_wused,
    output logic [WORD_BITS-1:0]                  o_mem_wend,
    input  logic [WORD_BITS-1:0]                  i_mem_rused,
    input  logic [WORD_BITS-1:0]                  i_mem_rend
);

    localparam int NW    = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA    = word_addr_bits(NUM_PAGES);
    localparam int PG_W  = WA + OFF_W;
    localparam int LIM_W = PG_W + 1;
    localparam int IDX_W = ADDR_W - PAGE_SHIFT;
    localparam int CW    = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int FW    = ((PG_W > CNT_W) ? PG_W : CNT_W) + 1;
    localparam logic [WA-1:0] LAST_WORD = WA'(NW - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PREP, S_FCHK, S_SEARCH, S_MARK_RD, S_MARK_WR, S_FREE, S_FINISH
    } t_state;

    t_state              r_state;
    logic                r_cmd;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_diff;
    logic                r_below;
    logic [LIM_W-1:0]    r_limit;
    logic [WA-1:0]       r_k;
    logic [OFF_W-1:0]    r_off;
    logic [RUN_W-1:0]    r_carry;
    logic [WA-1:0]       r_last_k;
    logic [OFF_W-1:0]    r_last_off;
    logic [PG_W-1:0]     r_first;
    logic [STAT_W-1:0]   r_res_status;
    logic [ADDR_W-1:0]   r_res_addr;
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;

    logic [LIM_W-1:0]     limit_now;
    logic [WORD_BITS-1:0] in_map;
    logic [WA:0]          k_plus1;
    logic [LIM_W-1:0]     next_word_base;
    logic                 search_end;
    logic                 count_over;
    logic                 free_oor;
    logic [PG_W-1:0]      free_page;
    logic [FW-1:0]        first_full;
    logic [PG_W-1:0]      first_page;
    logic [OFF_W-1:0]     mark_lo;
    logic [OFF_W-1:0]     mark_hi;
    logic [WORD_BITS-1:0] mark_end;
    logic                 mem_we;
    t_search_res          srch;
    t_free_res            frel;

    // Pages in use saturate at the map size.
    assign limit_now = (32'(i_total) > NUM_PAGES) ? LIM_W'(NUM_PAGES) : LIM_W'(i_total);

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            in_map[j] = {1'b0, r_k, OFF_W'(j)} < r_limit;
        end
    end

    assign k_plus1        = {1'b0, r_k} + (WA + 1)'(1);
    assign next_word_base = {k_plus1, {OFF_W{1'b0}}};
    assign search_end     = next_word_base >= r_limit;
    assign count_over     = CW'(r_count) > CW'(r_limit);
    assign free_oor       = r_below || (r_diff[ADDR_W-1:PAGE_SHIFT] >= IDX_W'(r_limit));
    assign free_page      = r_diff[PAGE_SHIFT+PG_W-1:PAGE_SHIFT];
    assign first_full     = FW'({r_last_k, r_last_off}) + FW'(1) - FW'(r_count);
    assign first_page     = first_full[PG_W-1:0];

    assign mark_lo  = (r_k == r_first[PG_W-1:OFF_W]) ? r_first[OFF_W-1:0] : '0;
    assign mark_hi  = (r_k == r_last_k) ? r_last_off : OFF_W'(WORD_BITS - 1);
    assign mark_end = (r_k == r_last_k) ? (WORD_BITS'(1) << r_last_off) : {WORD_BITS{1'b0}};

    cpa_word_scan u_scan (
        .i_used   (i_mem_rused),
        .i_end    (i_mem_rend),
        .i_in_map (in_map),
        .i_carry  (r_carry),
        .i_count  (r_count),
        .i_off    (r_off),
        .o_search (srch),
        .o_free   (frel)
    );

    // While one word is written back the next is already being read; the two
    // addresses always differ, so no forwarding is needed.
    always_comb begin
        o_mem_raddr = r_k;
        mem_we      = 1'b0;
        o_mem_wused = '0;
        o_mem_wend  = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_PREP: begin
                o_mem_raddr = '0;
            end
            S_FCHK: begin
                o_mem_raddr = free_page[PG_W-1:OFF_W];
            end
            S_SEARCH: begin
                o_mem_raddr = k_plus1[WA-1:0];
            end
            S_MARK_RD: begin
                o_mem_raddr = first_page[PG_W-1:OFF_W];
            end
            S_MARK_WR: begin
                o_mem_raddr = k_plus1[WA-1:0];
                mem_we      = 1'b1;
                o_mem_wused = i_mem_rused | range_mask(mark_lo, mark_hi);
                o_mem_wend  = i_mem_rend | mark_end;
            end
            S_FREE: begin
                o_mem_raddr = k_plus1[WA-1:0];
                mem_we      = 1'b1;
                o_mem_wused = frel.used_word;
                o_mem_wend  = frel.end_word;
            end
            default: begin
            end
        endcase
    end

    assign o_mem_we    = mem_we;
    assign o_mem_waddr = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_limit <= limit_now;
            // The finish state loads the result register itself.
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_k <= r_k + WA'(1);
                    if (r_k == {WA{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_cmd;
                        r_count <= i_page_count;
                        r_addr  <= i_free_address;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_cmd == CMD_ALLOC) begin
                        r_res_addr <= '0;
                        if (r_count == '0) begin
                            r_res_status <= ST_BADCOUNT;
                            r_state      <= S_FINISH;
                        end else if (count_over) begin
                            r_res_status <= ST_NOFIT;
                            r_state      <= S_FINISH;
                        end else begin
                            r_k     <= '0;
                            r_carry <= '0;
                            r_state <= S_SEARCH;
                        end
                    end else begin
                        {r_below, r_diff} <= {1'b0, r_addr} - {1'b0, i_base};
                        r_state           <= S_FCHK;
                    end
                end
                S_FCHK: begin
                    r_res_addr <= '0;
                    if (free_oor) begin
                        r_res_status <= ST_RANGE;
                        r_state      <= S_FINISH;
                    end else begin
                        r_k     <= free_page[PG_W-1:OFF_W];
                        r_off   <= free_page[OFF_W-1:0];
                        r_state <= S_FREE;
                    end
                end
                S_SEARCH: begin
                    if (srch.hit) begin
                        r_last_k   <= r_k;
                        r_last_off <= srch.pos;
                        r_state    <= S_MARK_RD;
                    end else if (search_end) begin
                        r_res_status <= ST_NOFIT;
                        r_res_addr   <= '0;
                        r_state      <= S_FINISH;
                    end else begin
                        r_k     <= k_plus1[WA-1:0];
                        r_carry <= srch.carry;
                    end
                end
                S_MARK_RD: begin
                    r_first <= first_page;
                    r_k     <= first_page[PG_W-1:OFF_W];
                    r_state <= S_MARK_WR;
                end
                S_MARK_WR: begin
                    if (r_k == r_last_k) begin
                        r_res_status <= ST_DONE;
                        r_res_addr   <= i_base + (ADDR_W'(r_first) << PAGE_SHIFT);
                        r_state      <= S_FINISH;
                    end else begin
                        r_k <= k_plus1[WA-1:0];
                    end
                end
                S_FREE: begin
                    if (frel.found || (r_k == LAST_WORD)) begin
                        r_res_status <= ST_DONE;
                        r_res_addr   <= '0;
                        r_state      <= S_FINISH;
                    end else begin
                        r_k   <= k_plus1[WA-1:0];
                        r_off <= '0;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_addr   <= r_res_addr;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_alloc_address = r_out_addr;

    // The run carried between words never reaches the request, else a hit was missed.
    a_carry_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_carry < RUN_W'(r_count)))
        else $error("search carry reached the requested page count");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_DONE)) |-> (r_out_addr == '0))
        else $error("failed transaction carries a nonzero address");

    a_mark_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK_WR) |-> (r_k <= r_last_k))
        else $error("marking walked past the last word of the run");

    a_no_stray_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_SEARCH || r_state == S_FINISH) |-> !mem_we)
        else $error("page map written outside clearing, marking or release");

endmodule
